@@ rtl/mono_framebuffer_rect_fill_assert.svh @@
// Assertion macros for the frame store rectangle fill block.
`ifndef MONO_FRAMEBUFFER_RECT_FILL_ASSERT_SVH
`define MONO_FRAMEBUFFER_RECT_FILL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MFB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MFB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mfb_pkg.sv @@
// Shared constants, types and pixel update function for the frame store fill block.
`timescale 1ns / 1ps
`default_nettype none

package mfb_pkg;

	localparam int ROW_BYTES   = 16;
	localparam int ROWS        = 64;
	localparam int STORE_BYTES = ROW_BYTES * ROWS;
	localparam int ROW_PIXELS  = ROW_BYTES * 8;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int ROW_W       = $clog2(ROWS);
	localparam int COL_W       = $clog2(ROW_BYTES);
	localparam int XE_W        = ($clog2(ROW_PIXELS + 1) > 9) ? $clog2(ROW_PIXELS + 1) : 9;
	localparam int YE_W        = ($clog2(ROWS + 1) > 8) ? $clog2(ROWS + 1) : 8;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_SET    = 2'd1,
		MODE_TOGGLE = 2'd2,
		MODE_HOLD   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CMD_DRAW  = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REQ_READ   = 2'd0,
		REQ_MODIFY = 2'd1,
		REQ_ZERO   = 2'd2
	} req_kind_t;

	typedef struct packed {
		logic              valid;
		req_kind_t         kind;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        mask;
	} store_req_t;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'd0,
		ST_IDLE  = 3'd1,
		ST_DRAW  = 3'd2,
		ST_READ  = 3'd3,
		ST_DONE  = 3'd4
	} state_t;

	function automatic logic [7:0] apply_mask(input logic [7:0] data, input logic [7:0] mask,
		input mode_t mode);
		logic [7:0] res;
		res = data;
		case (mode)
			MODE_CLEAR:  res = data & ~mask;
			MODE_SET:    res = data | mask;
			MODE_TOGGLE: res = data ^ mask;
			default:     res = data;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

@@ rtl/mfb_store.sv @@
// Frame store memory with a registered read and a read-modify-write stage.
`timescale 1ns / 1ps
`default_nettype none

module mfb_store
	import mfb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire store_req_t req,
	input  wire mode_t      mode,
	output logic [7:0]      rdata
);

	logic [7:0]        mem [STORE_BYTES];
	logic [7:0]        rdata_q;
	logic              mod_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        mask_s1;
	logic              rd_en;

	assign rd_en = req.valid && (req.kind == REQ_READ || req.kind == REQ_MODIFY);
	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (mod_s1) begin
			mem[addr_s1] <= apply_mask(rdata_q, mask_s1, mode);
		end else if (req.valid && req.kind == REQ_ZERO) begin
			mem[req.addr] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_s1 <= 1'b0;
		end else begin
			mod_s1 <= req.valid && req.kind == REQ_MODIFY;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= req.addr;
		mask_s1 <= req.mask;
	end

endmodule

`default_nettype wire

@@ rtl/mono_framebuffer_rect_fill.sv @@
// One command is handled at a time, paced by the store's single read-modify-write port: a draw
// walks each touched byte (rows times bytes per row), a read fetches one byte and a clear
// zeroes the whole store.
// Results wait in an output register, so the next transaction is taken while one is held.
// After reset the store is zeroed by a sweep over every byte before the first transaction.
`timescale 1ns / 1ps
`default_nettype none
`include "mono_framebuffer_rect_fill_assert.svh"

module mono_framebuffer_rect_fill
	import mfb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] cmd,
	input  wire logic [6:0] x_pos,
	input  wire logic [5:0] y_pos,
	input  wire logic [7:0] rect_width,
	input  wire logic [6:0] rect_height,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      read_data
);

	state_t            st_q, st_d;
	mode_t             draw_mode_q;
	store_req_t        req;
	logic [7:0]        rdata;
	logic              out_load;
	logic              accept;

	logic [ADDR_W-1:0] clr_addr_q;
	logic              resp_q;
	logic [7:0]        resp_data_q;
	logic [ROW_W-1:0]  row_q, rlast_q;
	logic [COL_W-1:0]  byte_q, bfirst_q, blast_q;
	logic [2:0]        lo_q;
	logic [3:0]        hi_q;
	logic              out_valid_q;
	logic [7:0]        read_data_q;

	logic [XE_W-1:0]   x_end, x1, x1m;
	logic [YE_W-1:0]   y_end, y1;
	logic              draw_empty;
	logic [6:0]        rd_col;
	logic              rd_in_range;
	logic [ADDR_W-1:0] rd_addr, draw_addr;
	logic [2:0]        lo;
	logic [3:0]        hi;
	logic [7:0]        mask;

	mfb_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.mode   (draw_mode_q),
		.rdata  (rdata)
	);

	assign x_end      = XE_W'(x_pos) + XE_W'(rect_width);
	assign x1         = (x_end > XE_W'(ROW_PIXELS)) ? XE_W'(ROW_PIXELS) : x_end;
	assign x1m        = x1 - XE_W'(1);
	assign y_end      = YE_W'(y_pos) + YE_W'(rect_height);
	assign y1         = (y_end > YE_W'(ROWS)) ? YE_W'(ROWS) : y_end;
	assign draw_empty = (XE_W'(x_pos) >= x1) || (YE_W'(y_pos) >= y1);

	assign rd_col      = x_pos >> 3;
	assign rd_in_range = (XE_W'(rd_col) < XE_W'(ROW_BYTES)) && (YE_W'(y_pos) < YE_W'(ROWS));
	assign rd_addr     = ADDR_W'(y_pos) * ADDR_W'(ROW_BYTES) + ADDR_W'(rd_col);

	assign draw_addr = ADDR_W'(row_q) * ADDR_W'(ROW_BYTES) + ADDR_W'(byte_q);
	assign lo        = (byte_q == bfirst_q) ? lo_q : 3'd0;
	assign hi        = (byte_q == blast_q) ? hi_q : 4'd8;
	assign mask      = (8'hff >> lo) & ~(8'hff >> hi);

	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	always_comb begin
		st_d     = st_q;
		req      = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (st_q)
			ST_CLEAR: begin
				req.valid = 1'b1;
				req.kind  = REQ_ZERO;
				req.addr  = clr_addr_q;
				if (clr_addr_q == ADDR_W'(STORE_BYTES - 1)) begin
					st_d = resp_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (cmd)
						CMD_DRAW:  st_d = draw_empty ? ST_DONE : ST_DRAW;
						CMD_CLEAR: st_d = ST_CLEAR;
						CMD_READ: begin
							if (rd_in_range) begin
								req.valid = 1'b1;
								req.kind  = REQ_READ;
								req.addr  = rd_addr;
								st_d      = ST_READ;
							end else begin
								st_d = ST_DONE;
							end
						end
						default:   st_d = ST_DONE;
					endcase
				end
			end
			ST_DRAW: begin
				req.valid = 1'b1;
				req.kind  = REQ_MODIFY;
				req.addr  = draw_addr;
				req.mask  = mask;
				if (byte_q == blast_q && row_q == rlast_q) begin
					st_d = ST_DONE;
				end
			end
			ST_READ: st_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_mode_q <= MODE_TOGGLE;
		end else if (cfg_we) begin
			draw_mode_q <= mode_t'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			resp_q      <= 1'b0;
			resp_data_q <= '0;
			row_q       <= '0;
			rlast_q     <= '0;
			byte_q      <= '0;
			bfirst_q    <= '0;
			blast_q     <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
		end else begin
			if (st_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (accept) begin
				clr_addr_q  <= '0;
				resp_q      <= 1'b1;
				resp_data_q <= '0;
				row_q       <= ROW_W'(y_pos);
				rlast_q     <= ROW_W'(y1 - YE_W'(1));
				byte_q      <= COL_W'(x_pos >> 3);
				bfirst_q    <= COL_W'(x_pos >> 3);
				blast_q     <= COL_W'(x1m >> 3);
				lo_q        <= x_pos[2:0];
				hi_q        <= {1'b0, x1m[2:0]} + 4'd1;
			end
			if (out_load) begin
				resp_q <= 1'b0;
			end
			if (st_q == ST_READ) begin
				resp_data_q <= rdata;
			end
			if (st_q == ST_DRAW) begin
				if (byte_q == blast_q) begin
					byte_q <= bfirst_q;
					row_q  <= row_q + ROW_W'(1);
				end else begin
					byte_q <= byte_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			read_data_q <= '0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			read_data_q <= resp_data_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	`MFB_ASSERT_NOW(a_read_follows_accept, st_q == ST_READ, $past(in_valid && in_ready), "read phase without a preceding transaction")
	`MFB_ASSERT_NOW(a_draw_in_span, st_q == ST_DRAW, row_q <= rlast_q && byte_q >= bfirst_q && byte_q <= blast_q, "draw walker left its span")
	`MFB_ASSERT_NEXT(a_result_only_from_done, st_q != ST_DONE && !out_valid_q, !out_valid_q, "result raised outside completion")

endmodule

`default_nettype wire
